@@ design/bthome_v2_payload_parser_macros.svh @@
// ----------------------------------------------------------------------------
// BTHome v2 payload parser assertion macros
// Concurrent assertion shorthands clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BTHOME_V2_PAYLOAD_PARSER_MACROS_SVH
`define BTHOME_V2_PAYLOAD_PARSER_MACROS_SVH

// Same-cycle implication.
`define BTP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define BTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed: next-cycle implication");

`endif

@@ design/btp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// BTHome v2 payload parser package
// Request types, object ids, and decode helpers shared by the parser.
// ----------------------------------------------------------------------------
package btp_pkg;

    // Info byte fields.
    localparam logic [2:0] VERSION_TWO   = 3'b010;
    localparam int         INFO_ENC_BIT  = 0;
    localparam int         INFO_TRIG_BIT = 2;

    // Object ids.
    localparam logic [7:0] OBJ_PACKET_ID  = 8'h00;
    localparam logic [7:0] OBJ_BATTERY    = 8'h01;
    localparam logic [7:0] OBJ_TEMP_CENTI = 8'h02;
    localparam logic [7:0] OBJ_HUM_CENTI  = 8'h03;
    localparam logic [7:0] OBJ_HUM_PCT    = 8'h2E;
    localparam logic [7:0] OBJ_BUTTON     = 8'h3A;
    localparam logic [7:0] OBJ_TEMP_DECI  = 8'h45;

    // Value lengths.
    localparam logic [1:0] OBJ_LEN_NONE = 2'd0;
    localparam logic [1:0] OBJ_LEN_ONE  = 2'd1;
    localparam logic [1:0] OBJ_LEN_TWO  = 2'd2;

    // Button event coding.
    localparam logic [7:0] BTN_RAW_MAX      = 8'h06;
    localparam logic [7:0] BTN_RAW_HOLD     = 8'h80;
    localparam logic [3:0] BTN_CODE_NONE    = 4'd0;
    localparam logic [3:0] BTN_CODE_HOLD    = 4'd8;
    localparam logic [3:0] BTN_CODE_UNKNOWN = 4'd9;

    // Scaling of the percent humidity object to hundredths.
    localparam logic [15:0] HUM_SCALE = 16'd100;

    // Seen flag positions.
    localparam int SEEN_PKT  = 0;
    localparam int SEEN_BAT  = 1;
    localparam int SEEN_HUM  = 2;
    localparam int SEEN_TEMP = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_req;

    typedef struct packed {
        logic               ok;
        logic               encrypted;
        logic               trigger_based;
        logic [7:0]         packet_number;
        logic               packet_number_seen;
        logic [7:0]         battery_percent;
        logic               battery_seen;
        logic [15:0]        humidity_centi;
        logic               humidity_seen;
        logic signed [19:0] temperature_centi;
        logic               temperature_seen;
        logic [3:0]         button_event;
    } t_out_req;

    function automatic logic [1:0] object_length(input logic [7:0] id);
        logic [1:0] len;
        case (id)
            OBJ_PACKET_ID, OBJ_BATTERY, OBJ_HUM_PCT, OBJ_BUTTON: len = OBJ_LEN_ONE;
            OBJ_HUM_CENTI, OBJ_TEMP_DECI, OBJ_TEMP_CENTI:        len = OBJ_LEN_TWO;
            default:                                             len = OBJ_LEN_NONE;
        endcase
        return len;
    endfunction

    function automatic logic [3:0] button_code(input logic [7:0] v);
        logic [3:0] code;
        if (v <= BTN_RAW_MAX) begin
            code = v[3:0] + 4'd1;
        end else if (v == BTN_RAW_HOLD) begin
            code = BTN_CODE_HOLD;
        end else begin
            code = BTN_CODE_UNKNOWN;
        end
        return code;
    endfunction

endpackage
`default_nettype wire

@@ design/bthome_v2_payload_parser.sv @@
`default_nettype none
// A record's last byte is accepted into the input register; the record is valid once the output register takes it.
// Throughput: one byte per cycle; the update of the parse state for each byte bounds it.
// A result that waits in the output register only holds off a later last byte.
// Reset (synchronous, active low) returns the parser to expecting an info byte
// and empties the input and output registers.
// ----------------------------------------------------------------------------
// BTHome v2 payload parser
// Streams advertisement payload bytes, decodes the info byte and the known
// sensor objects, and emits one record with seen flags per packet.
// ----------------------------------------------------------------------------
module bthome_v2_payload_parser
    import btp_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_stall,
    input  wire t_in_req i_in_req,
    output logic      o_out_valid,
    input  wire       i_out_stall,
    output t_out_req  o_out_req
);

    // Parse phase: an unencrypted version two info byte opens a packet, then id and
    // value bytes alternate; any other info byte or an unknown id goes to the skip phase.
    typedef enum logic [1:0] {
        PH_INFO  = 2'd0,
        PH_OBJ   = 2'd1,
        PH_VALUE = 2'd2,
        PH_SKIP  = 2'd3
    } t_phase;

    // Input register.
    logic    r_s1_valid;
    t_in_req r_s1;

    // Parse state.
    t_phase             r_phase,       n_phase;
    logic [7:0]         r_cur_obj,     n_cur_obj;
    logic [7:0]         r_low_byte,    n_low_byte;
    logic               r_second_half, n_second_half;
    logic [7:0]         r_pkt_num,     n_pkt_num;
    logic [7:0]         r_battery,     n_battery;
    logic [15:0]        r_humidity,    n_humidity;
    logic signed [19:0] r_temp,        n_temp;
    logic [3:0]         r_button,      n_button;
    logic [3:0]         r_seen,        n_seen;
    logic               r_hdr_ok,      n_hdr_ok;
    logic               r_hdr_enc,     n_hdr_enc;
    logic               r_hdr_trig,    n_hdr_trig;

    // Output register.
    logic     r_out_valid;
    t_out_req r_out;
    t_out_req n_out;

    logic               s1_go;
    logic               in_accept;
    logic [7:0]         b;
    logic [15:0]        raw16;
    logic signed [19:0] raw_sext;
    logic signed [19:0] raw_x10;

    // A byte that ends a packet needs room in the output register; every
    // other byte only updates the parse state and always moves on.
    assign s1_go     = r_s1_valid && !(r_s1.last_byte && r_out_valid && i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_accept = i_in_valid && !o_in_stall;

    assign b        = r_s1.data_byte;
    assign raw16    = {b, r_low_byte};
    assign raw_sext = {{4{raw16[15]}}, raw16};
    // Times ten as two shifted copies; the product always fits in 20 bits.
    assign raw_x10  = (raw_sext <<< 3) + (raw_sext <<< 1);

    always_comb begin
        n_phase       = r_phase;
        n_cur_obj     = r_cur_obj;
        n_low_byte    = r_low_byte;
        n_second_half = r_second_half;
        n_pkt_num     = r_pkt_num;
        n_battery     = r_battery;
        n_humidity    = r_humidity;
        n_temp        = r_temp;
        n_button      = r_button;
        n_seen        = r_seen;
        n_hdr_ok      = r_hdr_ok;
        n_hdr_enc     = r_hdr_enc;
        n_hdr_trig    = r_hdr_trig;

        if (s1_go) begin
            unique case (r_phase)
                PH_INFO: begin
                    // A new packet starts from clean values.
                    n_cur_obj     = '0;
                    n_low_byte    = '0;
                    n_second_half = 1'b0;
                    n_pkt_num     = '0;
                    n_battery     = '0;
                    n_humidity    = '0;
                    n_temp        = '0;
                    n_button      = '0;
                    n_seen        = '0;
                    n_hdr_enc     = b[INFO_ENC_BIT];
                    n_hdr_trig    = b[INFO_TRIG_BIT];
                    n_hdr_ok      = (b[7:5] == VERSION_TWO);
                    n_phase       = ((b[7:5] == VERSION_TWO) && !b[INFO_ENC_BIT])
                                    ? PH_OBJ : PH_SKIP;
                end
                PH_OBJ: begin
                    n_cur_obj     = b;
                    n_second_half = 1'b0;
                    n_phase       = (object_length(b) != OBJ_LEN_NONE) ? PH_VALUE : PH_SKIP;
                end
                PH_VALUE: begin
                    case (object_length(r_cur_obj))
                        OBJ_LEN_ONE: begin
                            case (r_cur_obj)
                                OBJ_PACKET_ID: begin
                                    n_pkt_num        = b;
                                    n_seen[SEEN_PKT] = 1'b1;
                                end
                                OBJ_BATTERY: begin
                                    n_battery        = b;
                                    n_seen[SEEN_BAT] = 1'b1;
                                end
                                OBJ_HUM_PCT: begin
                                    n_humidity       = 16'({8'h00, b} * HUM_SCALE);
                                    n_seen[SEEN_HUM] = 1'b1;
                                end
                                OBJ_BUTTON: begin
                                    n_button = button_code(b);
                                end
                                default: begin
                                end
                            endcase
                            n_phase = PH_OBJ;
                        end
                        OBJ_LEN_TWO: begin
                            if (!r_second_half) begin
                                n_low_byte    = b;
                                n_second_half = 1'b1;
                            end else begin
                                case (r_cur_obj)
                                    OBJ_HUM_CENTI: begin
                                        n_humidity       = raw16;
                                        n_seen[SEEN_HUM] = 1'b1;
                                    end
                                    OBJ_TEMP_DECI: begin
                                        n_temp            = raw_x10;
                                        n_seen[SEEN_TEMP] = 1'b1;
                                    end
                                    OBJ_TEMP_CENTI: begin
                                        n_temp            = raw_sext;
                                        n_seen[SEEN_TEMP] = 1'b1;
                                    end
                                    default: begin
                                    end
                                endcase
                                n_second_half = 1'b0;
                                n_phase       = PH_OBJ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                PH_SKIP: begin
                end
                default: begin
                end
            endcase

            // The last byte always closes the packet, even inside a value.
            if (r_s1.last_byte) begin
                n_phase       = PH_INFO;
                n_second_half = 1'b0;
            end
        end
    end

    // The record reflects the state after the last byte has been applied.
    always_comb begin
        n_out.ok                 = n_hdr_ok;
        n_out.encrypted          = n_hdr_enc;
        n_out.trigger_based      = n_hdr_trig;
        n_out.packet_number      = n_pkt_num;
        n_out.packet_number_seen = n_seen[SEEN_PKT];
        n_out.battery_percent    = n_battery;
        n_out.battery_seen       = n_seen[SEEN_BAT];
        n_out.humidity_centi     = n_humidity;
        n_out.humidity_seen      = n_seen[SEEN_HUM];
        n_out.temperature_centi  = n_temp;
        n_out.temperature_seen   = n_seen[SEEN_TEMP];
        n_out.button_event       = n_button;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase       <= PH_INFO;
            r_second_half <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_go && r_s1.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            r_phase       <= n_phase;
            r_second_half <= n_second_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= i_in_req;
        end
        if (s1_go && r_s1.last_byte) begin
            r_out <= n_out;
        end
        r_cur_obj  <= n_cur_obj;
        r_low_byte <= n_low_byte;
        r_pkt_num  <= n_pkt_num;
        r_battery  <= n_battery;
        r_humidity <= n_humidity;
        r_temp     <= n_temp;
        r_button   <= n_button;
        r_seen     <= n_seen;
        r_hdr_ok   <= n_hdr_ok;
        r_hdr_enc  <= n_hdr_enc;
        r_hdr_trig <= n_hdr_trig;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

`include "bthome_v2_payload_parser_macros.svh"

    `BTP_ASSERT_NEXT(a_last_closes_packet, s1_go && r_s1.last_byte, r_out_valid && r_phase == PH_INFO)
    `BTP_ASSERT_IMPLY(a_value_has_known_id, r_phase == PH_VALUE, object_length(r_cur_obj) != OBJ_LEN_NONE)
    `BTP_ASSERT_IMPLY(a_second_half_two_byte, r_second_half, r_phase == PH_VALUE && object_length(r_cur_obj) == OBJ_LEN_TWO)
    `BTP_ASSERT_IMPLY(a_bad_version_no_values, r_out_valid && !r_out.ok, !r_out.packet_number_seen && !r_out.battery_seen && !r_out.humidity_seen && !r_out.temperature_seen && r_out.button_event == BTN_CODE_NONE)

endmodule
`default_nettype wire
